/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ARP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ARP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARP_ASSERT(lbl, clk, rstn, prop, msg)
`define ARP_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* rtl/arp_pkg.sv */
package arp_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int AGE_W   = 32;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic OP_LEARN  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic clear;
        logic eval;
        idx_t idx;
        logic valid;
    } scan_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] match_mac;
        idx_t             slot;
    } scan_res_t;

endpackage

/* rtl/arp_ram.sv */
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/arp_scan.sv */
module arp_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [arp_pkg::IP_W-1:0]  ip_key,
    input  arp_pkg::scan_ctrl_t       ctrl,
    input  arp_pkg::rec_t             rec,
    output arp_pkg::scan_res_t        res
);

    logic                        match_found_reg, match_found_next;
    arp_pkg::idx_t               match_idx_reg, match_idx_next;
    logic [arp_pkg::MAC_W-1:0]   match_mac_reg, match_mac_next;
    logic                        free_found_reg, free_found_next;
    arp_pkg::idx_t               free_idx_reg, free_idx_next;
    arp_pkg::idx_t               min_idx_reg, min_idx_next;
    logic [arp_pkg::AGE_W-1:0]   min_age_reg, min_age_next;

    logic ip_eq;
    logic age_lt;
    logic take_min;

    // shared compare unit, one entry per cycle
    assign ip_eq    = (rec.ip == ip_key);
    assign age_lt   = (rec.age < min_age_reg);
    assign take_min = (ctrl.idx == '0) || age_lt;

    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_mac_next   = match_mac_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        min_idx_next     = min_idx_reg;
        min_age_next     = min_age_reg;
        if (ctrl.clear)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else if (ctrl.eval)
        begin
            // keep the first valid match
            if (ctrl.valid && ip_eq && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = ctrl.idx;
                match_mac_next   = rec.mac;
            end
            if (!ctrl.valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ctrl.idx;
            end
            // strict less-than keeps the lowest index on a tie
            if (take_min)
            begin
                min_idx_next = ctrl.idx;
                min_age_next = rec.age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        free_idx_reg  <= free_idx_next;
        min_idx_reg   <= min_idx_next;
        min_age_reg   <= min_age_next;
    end

    always_comb
    begin
        res.hit       = match_found_reg;
        res.match_mac = match_mac_reg;
        if (match_found_reg)
        begin
            res.slot = match_idx_reg;
        end
        else if (free_found_reg)
        begin
            res.slot = free_idx_reg;
        end
        else
        begin
            res.slot = min_idx_reg;
        end
    end

endmodule

/* rtl/arp_cache_lru_core.sv */
// Channel  Handshake            Payload
// input    in_valid/in_stall    operation, ip_address, mac_address
// output   out_valid/out_stall  hit, mac_found
//
// An item passes through these steps in order: accept, one table read per entry through the
// single compare unit, a drain of the last read, and write-back.
// in_stall stays high from accept until write-back; a pending result does not block accept.
// A lookup write-back waits while the output register holds an item under out_stall.
// rst_n clears all entries invalid and the use counter; table contents need no clearing.
`include "assert_macros.svh"

module arp_cache_lru_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [arp_pkg::IP_W-1:0]   ip_address,
    input  logic [arp_pkg::MAC_W-1:0]  mac_address,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [arp_pkg::MAC_W-1:0]  mac_found
);

    arp_pkg::state_t             state_reg, state_next;
    arp_pkg::idx_t               idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    arp_pkg::idx_t               pend_idx_reg, pend_idx_next;
    logic                        op_reg, op_next;
    logic [arp_pkg::IP_W-1:0]    ip_reg, ip_next;
    logic [arp_pkg::MAC_W-1:0]   mac_reg, mac_next;
    logic [arp_pkg::ENTRIES-1:0] valid_reg, valid_next;
    logic [arp_pkg::AGE_W-1:0]   use_clock_reg, use_clock_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        hit_reg, hit_next;
    logic [arp_pkg::MAC_W-1:0]   mac_found_reg, mac_found_next;

    logic                        ram_wr_en;
    logic                        ram_rd_en;
    arp_pkg::rec_t               wr_rec;
    logic [arp_pkg::REC_W-1:0]   ram_rd_data;
    arp_pkg::rec_t               rd_rec;
    arp_pkg::scan_ctrl_t         scan_ctrl;
    arp_pkg::scan_res_t          scan_res;
    logic                        out_busy;

    assign rd_rec   = arp_pkg::rec_t'(ram_rd_data);
    assign out_busy = out_valid_reg && out_stall;

    arp_ram #(
        .WIDTH (arp_pkg::REC_W),
        .DEPTH (arp_pkg::ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (scan_res.slot),
        .wr_data (wr_rec),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    arp_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ip_key (ip_reg),
        .ctrl   (scan_ctrl),
        .rec    (rd_rec),
        .res    (scan_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = idx_reg;
        op_next        = op_reg;
        ip_next        = ip_reg;
        mac_next       = mac_reg;
        valid_next     = valid_reg;
        use_clock_next = use_clock_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_next       = hit_reg;
        mac_found_next = mac_found_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        in_stall       = 1'b1;

        scan_ctrl.clear = 1'b0;
        scan_ctrl.eval  = pend_reg;
        scan_ctrl.idx   = pend_idx_reg;
        scan_ctrl.valid = valid_reg[pend_idx_reg];

        wr_rec.ip  = ip_reg;
        wr_rec.mac = (op_reg == arp_pkg::OP_LEARN) ? mac_reg : scan_res.match_mac;
        wr_rec.age = use_clock_reg + 1'b1;

        case (state_reg)
            arp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    op_next         = operation;
                    ip_next         = ip_address;
                    mac_next        = mac_address;
                    idx_next        = '0;
                    scan_ctrl.clear = 1'b1;
                    state_next      = arp_pkg::ST_SCAN;
                end
            end
            arp_pkg::ST_SCAN:
            begin
                ram_rd_en     = 1'b1;
                pend_next     = 1'b1;
                pend_idx_next = idx_reg;
                if (idx_reg == arp_pkg::LAST_IDX)
                begin
                    state_next = arp_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            arp_pkg::ST_DRAIN:
            begin
                state_next = arp_pkg::ST_FINISH;
            end
            arp_pkg::ST_FINISH:
            begin
                if (op_reg == arp_pkg::OP_LEARN)
                begin
                    ram_wr_en                 = 1'b1;
                    valid_next[scan_res.slot] = 1'b1;
                    use_clock_next            = use_clock_reg + 1'b1;
                    state_next                = arp_pkg::ST_IDLE;
                end
                else if (!out_busy)
                begin
                    // refresh the age of a hit; a miss leaves the table alone
                    ram_wr_en      = scan_res.hit;
                    if (scan_res.hit)
                    begin
                        use_clock_next = use_clock_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    hit_next       = scan_res.hit;
                    mac_found_next = scan_res.hit ? scan_res.match_mac : '0;
                    state_next     = arp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arp_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            use_clock_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            use_clock_reg <= use_clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        op_reg        <= op_next;
        ip_reg        <= ip_next;
        mac_reg       <= mac_next;
        hit_reg       <= hit_next;
        mac_found_reg <= mac_found_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign mac_found = mac_found_reg;

    `ARP_ASSERT(a_miss_zero_mac, clk, rst_n, (out_valid_reg && !hit_reg) |-> (mac_found_reg == '0), "miss with nonzero mac")
    `ARP_ASSERT(a_clock_only_finish, clk, rst_n, (state_reg != arp_pkg::ST_FINISH) |=> $stable(use_clock_reg), "use counter moved outside write-back")
    `ARP_ASSERT(a_valid_sticky, clk, rst_n, 1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)), "entry lost its valid bit")
    `ARP_ASSERT_NR(a_pend_in_scan, clk, pend_reg |-> (state_reg == arp_pkg::ST_SCAN || state_reg == arp_pkg::ST_DRAIN), "read pending outside scan")

endmodule
